### sv/reliable_rx_sequence_filter_macros.svh
// Assertion macros used by the checker file of the receive sequence filter.
// No dependencies; include by bare file name.
`ifndef RELIABLE_RX_SEQUENCE_FILTER_MACROS_SVH
`define RELIABLE_RX_SEQUENCE_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define RRSF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define RRSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rrsf_pkg.sv
// Package for the receive sequence filter: codes, item and result types.
// No dependencies; imported by every module of the block.
`default_nettype none

package rrsf_pkg;

    localparam int IN_DATA_W  = 232;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 120;
    localparam int OUT_USER_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAMP_VALUE  = 1'b1;

    localparam logic [7:0]  HEADER_RESET = 8'd39;
    localparam logic [31:0] STAMP_RESET  = 32'h5357_5050;

    localparam logic [7:0] TYPE_IMPORTANT = 8'hA5;
    localparam logic [7:0] TYPE_SIMPLE    = 8'hBD;
    localparam logic [7:0] TYPE_PARTIAL   = 8'h5A;
    localparam logic [7:0] TYPE_ACK       = 8'hCA;
    localparam logic [7:0] TYPE_CANCEL    = 8'hD7;

    localparam logic [15:0] IMPORTANT_MIN = 16'd4;
    localparam logic [15:0] PARTIAL_MIN   = 16'd9;
    localparam logic [15:0] CTRL_SIZE     = 16'd4;
    localparam logic [3:0]  IMPORTANT_OFS = 4'd4;
    localparam logic [3:0]  PARTIAL_OFS   = 4'd9;

    typedef enum logic [2:0] {
        ACT_CONNECT       = 3'd0,
        ACT_DISCONNECT    = 3'd1,
        ACT_RECEIVE       = 3'd2,
        ACT_NEXT_SEND     = 3'd3,
        ACT_ROLLBACK_SEND = 3'd4,
        ACT_NEXT_GROUP    = 3'd5
    } t_action;

    typedef enum logic [4:0] {
        VERD_DELIVER       = 5'd0,
        VERD_BAD_SIZE      = 5'd1,
        VERD_BAD_STAMP     = 5'd2,
        VERD_BAD_CHECKSUM  = 5'd3,
        VERD_MALFORMED     = 5'd4,
        VERD_NOT_CONNECTED = 5'd5,
        VERD_OUT_OF_ORDER  = 5'd6,
        VERD_DUPLICATE     = 5'd7,
        VERD_ACK_IN        = 5'd8,
        VERD_CANCEL_IN     = 5'd9,
        VERD_BAD_TYPE      = 5'd10,
        VERD_TOO_MANY_FRAG = 5'd11,
        VERD_FRAGMENT_IN   = 5'd12,
        VERD_CONNECTED     = 5'd13,
        VERD_TABLE_FULL    = 5'd14,
        VERD_DISCONNECTED  = 5'd15,
        VERD_UNKNOWN_PEER  = 5'd16
    } t_verdict;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] network;
        logic [63:0] node_socket;
        logic [31:0] stamp_word;
        logic        checksum_ok;
        logic [7:0]  packet_type;
        logic [15:0] link_length;
        logic [31:0] first_word;
        logic [31:0] frag_group;
        logic [7:0]  frag_total;
    } t_item;

    typedef struct packed {
        t_verdict    verdict;
        logic        send_ack;
        logic [31:0] ack_id;
        logic [31:0] id_out;
        logic [3:0]  data_offset;
        logic [15:0] data_size;
        logic [31:0] group_out;
    } t_result;

    // peer lookup status and counters of the matched slot
    typedef struct packed {
        logic        hit;
        logic        free_ok;
        logic [31:0] recv_seq;
        logic [31:0] send_seq;
        logic [31:0] group_seq;
    } t_lookup;

    // table update request for the selected slot
    typedef struct packed {
        logic alloc;
        logic zero_ctrs;
        logic release_slot;
        logic recv_inc;
        logic send_inc;
        logic send_dec;
        logic group_inc;
    } t_upd;

endpackage

`default_nettype wire

### sv/rrsf_peer_table.sv
// Peer table: valid bits, addresses and id counters, parallel address match,
// lowest-free-slot search and slot update. Depends on rrsf_pkg.
`default_nettype none

module rrsf_peer_table #(
    parameter int  CLIENT_SLOTS = 8,
    localparam int SW           = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [31:0]       i_network,
    input  wire logic [63:0]       i_node_socket,
    input  wire rrsf_pkg::t_upd    i_upd,
    output rrsf_pkg::t_lookup      o_lookup,
    output logic [SW-1:0]          o_sel_slot
);
    import rrsf_pkg::*;

    logic [CLIENT_SLOTS-1:0] r_valid;
    logic [31:0]             r_net   [CLIENT_SLOTS];
    logic [63:0]             r_ns    [CLIENT_SLOTS];
    logic [31:0]             r_recv  [CLIENT_SLOTS];
    logic [31:0]             r_send  [CLIENT_SLOTS];
    logic [31:0]             r_group [CLIENT_SLOTS];

    logic [CLIENT_SLOTS-1:0] match;
    logic [SW-1:0]           hit_idx;
    logic [SW-1:0]           free_idx;
    logic [31:0]             n_recv;
    logic [31:0]             n_send;
    logic [31:0]             n_group;

    // addresses are unique in the table, so an OR of matching indexes is exact
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < CLIENT_SLOTS; i++) begin
            match[i] = r_valid[i] && (r_net[i] == i_network) && (r_ns[i] == i_node_socket);
            hit_idx  = hit_idx | (match[i] ? SW'(i) : '0);
        end
        for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = SW'(i);
            end
        end
    end

    assign o_lookup.hit       = |match;
    assign o_lookup.free_ok   = ~&r_valid;
    assign o_lookup.recv_seq  = r_recv[hit_idx];
    assign o_lookup.send_seq  = r_send[hit_idx];
    assign o_lookup.group_seq = r_group[hit_idx];

    assign o_sel_slot = i_upd.alloc ? free_idx : hit_idx;

    assign n_recv  = r_recv[o_sel_slot] + 32'd1;
    assign n_send  = i_upd.send_dec ? (r_send[o_sel_slot] - 32'd1)
                                    : (r_send[o_sel_slot] + 32'd1);
    assign n_group = r_group[o_sel_slot] + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            if (i_upd.alloc) begin
                r_valid[o_sel_slot] <= 1'b1;
            end
            if (i_upd.release_slot) begin
                r_valid[o_sel_slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            if (i_upd.alloc) begin
                r_net[o_sel_slot] <= i_network;
                r_ns[o_sel_slot]  <= i_node_socket;
            end
            if (i_upd.zero_ctrs) begin
                r_recv[o_sel_slot]  <= '0;
                r_send[o_sel_slot]  <= '0;
                r_group[o_sel_slot] <= '0;
            end
            if (i_upd.recv_inc) begin
                r_recv[o_sel_slot] <= n_recv;
            end
            if (i_upd.send_inc || i_upd.send_dec) begin
                r_send[o_sel_slot] <= n_send;
            end
            if (i_upd.group_inc) begin
                r_group[o_sel_slot] <= n_group;
            end
        end
    end

endmodule

`default_nettype wire

### sv/rrsf_decide.sv
// Action decode and header checks: verdict, ack, ids, payload window and
// the table update for one item. Depends on rrsf_pkg.
`default_nettype none

module rrsf_decide #(
    parameter int FRAGMENT_LIMIT = 8
) (
    input  wire rrsf_pkg::t_item   i_item,
    input  wire logic [7:0]        i_header_bytes,
    input  wire logic [31:0]       i_stamp_value,
    input  wire rrsf_pkg::t_lookup i_lookup,
    output rrsf_pkg::t_result      o_res,
    output rrsf_pkg::t_upd         o_upd
);
    import rrsf_pkg::*;

    logic        short_pkt;
    logic [15:0] size;
    logic [15:0] min_size;
    logic [31:0] expect_id;
    logic        is_partial;

    assign short_pkt  = i_item.link_length < {8'd0, i_header_bytes};
    assign size       = i_item.link_length - {8'd0, i_header_bytes};
    assign is_partial = i_item.packet_type == TYPE_PARTIAL;
    assign min_size   = is_partial ? PARTIAL_MIN : IMPORTANT_MIN;
    assign expect_id  = i_lookup.recv_seq + 32'd1;

    always_comb begin
        o_res = '0;
        o_upd = '0;
        case (t_action'(i_item.action))
            ACT_CONNECT: begin
                if (i_lookup.hit) begin
                    o_upd.zero_ctrs = 1'b1;
                    o_res.verdict   = VERD_CONNECTED;
                end else if (i_lookup.free_ok) begin
                    o_upd.alloc     = 1'b1;
                    o_upd.zero_ctrs = 1'b1;
                    o_res.verdict   = VERD_CONNECTED;
                end else begin
                    o_res.verdict = VERD_TABLE_FULL;
                end
            end
            ACT_DISCONNECT: begin
                if (i_lookup.hit) begin
                    o_upd.release_slot = 1'b1;
                    o_res.verdict      = VERD_DISCONNECTED;
                end else begin
                    o_res.verdict = VERD_UNKNOWN_PEER;
                end
            end
            ACT_RECEIVE: begin
                if (short_pkt) begin
                    o_res.verdict = VERD_BAD_SIZE;
                end else if (i_item.stamp_word != i_stamp_value) begin
                    o_res.verdict = VERD_BAD_STAMP;
                end else if (!i_item.checksum_ok) begin
                    o_res.verdict = VERD_BAD_CHECKSUM;
                end else if (i_item.packet_type == TYPE_SIMPLE) begin
                    o_res.verdict   = VERD_DELIVER;
                    o_res.data_size = size;
                end else if (i_item.packet_type == TYPE_ACK ||
                             i_item.packet_type == TYPE_CANCEL) begin
                    if (size != CTRL_SIZE) begin
                        o_res.verdict = VERD_MALFORMED;
                    end else begin
                        o_res.id_out  = i_item.first_word;
                        o_res.verdict = (i_item.packet_type == TYPE_ACK) ? VERD_ACK_IN
                                                                         : VERD_CANCEL_IN;
                    end
                end else if (i_item.packet_type != TYPE_IMPORTANT && !is_partial) begin
                    o_res.verdict = VERD_BAD_TYPE;
                end else if (size < min_size) begin
                    o_res.verdict = VERD_MALFORMED;
                end else if (!i_lookup.hit) begin
                    o_res.verdict = VERD_NOT_CONNECTED;
                end else if (i_item.first_word > expect_id) begin
                    o_res.verdict = VERD_OUT_OF_ORDER;
                end else if (i_item.first_word != expect_id) begin
                    o_res.verdict  = VERD_DUPLICATE;
                    o_res.send_ack = 1'b1;
                    o_res.ack_id   = i_item.first_word;
                end else if (is_partial) begin
                    // a fragment needs header words plus at least one data byte
                    if (size == PARTIAL_MIN) begin
                        o_res.verdict = VERD_MALFORMED;
                    end else if (i_item.frag_total > 8'(FRAGMENT_LIMIT)) begin
                        o_res.verdict = VERD_TOO_MANY_FRAG;
                    end else begin
                        o_upd.recv_inc    = 1'b1;
                        o_res.verdict     = VERD_FRAGMENT_IN;
                        o_res.send_ack    = 1'b1;
                        o_res.ack_id      = i_item.first_word;
                        o_res.data_offset = PARTIAL_OFS;
                        o_res.data_size   = size - PARTIAL_MIN;
                        o_res.group_out   = i_item.frag_group;
                    end
                end else begin
                    o_upd.recv_inc    = 1'b1;
                    o_res.verdict     = VERD_DELIVER;
                    o_res.send_ack    = 1'b1;
                    o_res.ack_id      = i_item.first_word;
                    o_res.data_offset = IMPORTANT_OFS;
                    o_res.data_size   = size - IMPORTANT_MIN;
                end
            end
            ACT_NEXT_SEND: begin
                if (i_lookup.hit) begin
                    o_upd.send_inc = 1'b1;
                    o_res.id_out   = i_lookup.send_seq + 32'd1;
                end else begin
                    o_res.verdict = VERD_UNKNOWN_PEER;
                end
            end
            ACT_ROLLBACK_SEND: begin
                if (i_lookup.hit) begin
                    o_upd.send_dec = 1'b1;
                    o_res.id_out   = i_lookup.send_seq - 32'd1;
                end else begin
                    o_res.verdict = VERD_UNKNOWN_PEER;
                end
            end
            ACT_NEXT_GROUP: begin
                if (i_lookup.hit) begin
                    o_upd.group_inc = 1'b1;
                    o_res.id_out    = i_lookup.group_seq + 32'd1;
                end else begin
                    o_res.verdict = VERD_UNKNOWN_PEER;
                end
            end
            default: begin
                o_res.verdict = VERD_BAD_TYPE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/reliable_rx_sequence_filter.sv
// Top level of the receive sequence filter: stream ports, config registers,
// input and result registers. Depends on rrsf_pkg, rrsf_peer_table, rrsf_decide.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tuser action, tdata header fields
//   m_axis    out  m_axis_tvalid / m_axis_tready  tuser verdict, tdata result fields
//   cfg       in   i_cfg_we                       i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while m_axis accepts; results are registered.
// Lookup and table update of an item happen as its result is registered, so
// the next item sees the new table. Reset clears the table valid bits and
// both stage valids; no clearing pass. With m_axis stalled, the input
// register takes one more item and then s_axis_tready drops.
`default_nettype none

module reliable_rx_sequence_filter #(
    parameter int CLIENT_SLOTS   = 8,
    parameter int FRAGMENT_LIMIT = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: addr_network, addr_node_socket, stamp_word, checksum_ok,
    //        packet_type, link_length, first_word, frag_group, frag_total
    input  wire logic [rrsf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: action
    input  wire logic [rrsf_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata: send_ack, ack_id, id_out, client_slot, data_offset, data_size, group_out
    output logic [rrsf_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    // tuser: verdict
    output logic [rrsf_pkg::OUT_USER_W-1:0]          m_axis_tuser,
    input  wire logic                                i_cfg_we,
    input  wire logic [rrsf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rrsf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rrsf_pkg::*;

    localparam int SW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;

    logic                  r_in_valid;
    t_item                 r_in;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;
    logic [7:0]            r_header_bytes;
    logic [31:0]           r_stamp_value;

    t_item                 n_in;
    logic                  advance;
    logic                  fire;
    t_lookup               lookup;
    t_upd                  upd;
    t_result               res;
    logic [SW-1:0]         sel_slot;
    logic [SW+2:0]         slot_ext;

    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    assign n_in.action      = s_axis_tuser;
    assign n_in.network     = s_axis_tdata[31:0];
    assign n_in.node_socket = s_axis_tdata[95:32];
    assign n_in.stamp_word  = s_axis_tdata[127:96];
    assign n_in.checksum_ok = s_axis_tdata[128];
    assign n_in.packet_type = s_axis_tdata[136:129];
    assign n_in.link_length = s_axis_tdata[152:137];
    assign n_in.first_word  = s_axis_tdata[184:153];
    assign n_in.frag_group  = s_axis_tdata[216:185];
    assign n_in.frag_total  = s_axis_tdata[224:217];

    rrsf_peer_table #(
        .CLIENT_SLOTS (CLIENT_SLOTS)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_we          (fire),
        .i_network     (r_in.network),
        .i_node_socket (r_in.node_socket),
        .i_upd         (upd),
        .o_lookup      (lookup),
        .o_sel_slot    (sel_slot)
    );

    rrsf_decide #(
        .FRAGMENT_LIMIT (FRAGMENT_LIMIT)
    ) u_decide (
        .i_item         (r_in),
        .i_header_bytes (r_header_bytes),
        .i_stamp_value  (r_stamp_value),
        .i_lookup       (lookup),
        .o_res          (res),
        .o_upd          (upd)
    );

    assign slot_ext = {3'b000, sel_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_bytes <= HEADER_RESET;
            r_stamp_value  <= STAMP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEADER_BYTES: r_header_bytes <= i_cfg_data[7:0];
                CFG_STAMP_VALUE:  r_stamp_value  <= i_cfg_data;
                default:          r_stamp_value  <= r_stamp_value;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= n_in;
        end
        if (fire) begin
            r_out_user <= res.verdict;
            r_out_data <= {res.group_out, res.data_size, res.data_offset, slot_ext[2:0],
                           res.id_out, res.ack_id, res.send_ack};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

### sv/rrsf_checker.sv
// Port-level checks for the receive sequence filter, bound to the top level.
// Depends on rrsf_pkg and reliable_rx_sequence_filter_macros.svh.
`default_nettype none
`include "reliable_rx_sequence_filter_macros.svh"

module rrsf_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [rrsf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input wire logic [rrsf_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
    import rrsf_pkg::*;

    `RRSF_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    `RRSF_ASSERT_IMPL(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !m_axis_tvalid, "result valid right after reset")
    `RRSF_ASSERT_IMPL(a_ack_verdict, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tuser == VERD_DELIVER || m_axis_tuser == VERD_DUPLICATE || m_axis_tuser == VERD_FRAGMENT_IN, "ack request with wrong verdict")
    `RRSF_ASSERT_IMPL(a_offset_verdict, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[71:68] != 4'd0, (m_axis_tuser == VERD_DELIVER && m_axis_tdata[71:68] == IMPORTANT_OFS) || (m_axis_tuser == VERD_FRAGMENT_IN && m_axis_tdata[71:68] == PARTIAL_OFS), "payload offset does not fit verdict")

endmodule

bind reliable_rx_sequence_filter rrsf_checker u_rrsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### verif/tb.sv
// Testbench for reliable_rx_sequence_filter: peer table actions and packet headers,
// directed then random, each result checked against an in-bench predictor.
// Depends on rrsf_pkg and the block RTL.
module tb;
    import rrsf_pkg::*;

    localparam int PEER_SLOTS     = 8;
    localparam int FRAG_LIMIT     = 8;
    localparam int POOL_SIZE      = 12;
    localparam int SETTLE_CYCLES  = 4;
    localparam int STALL_LEN      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 300;

    localparam logic [2:0] ACT_RESERVED_A = 3'd6;
    localparam logic [2:0] ACT_RESERVED_B = 3'd7;
    localparam logic [7:0] TYPE_UNKNOWN   = 8'hFF;

    typedef struct packed {
        t_verdict    verdict;
        logic        send_ack;
        logic [31:0] ack_id;
        logic [31:0] id_out;
        logic [2:0]  slot;
        logic [3:0]  offset;
        logic [15:0] size;
        logic [31:0] group;
    } outcome_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [IN_USER_W-1:0]   s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [OUT_USER_W-1:0]  m_axis_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // predictor state
    logic [7:0]  cfg_hdr;
    logic [31:0] cfg_stamp;
    logic        peer_used [PEER_SLOTS];
    logic [31:0] peer_net  [PEER_SLOTS];
    logic [63:0] peer_ns   [PEER_SLOTS];
    logic [31:0] rx_last   [PEER_SLOTS];
    logic [31:0] tx_last   [PEER_SLOTS];
    logic [31:0] grp_last  [PEER_SLOTS];

    logic [31:0] pool_net [POOL_SIZE];
    logic [63:0] pool_ns  [POOL_SIZE];

    outcome_t awaited_outcomes [$];
    int  err_count;
    int  items_sent;
    int  results_seen;
    bit  verdict_seen [32];
    int  src_idle_pct;
    int  sink_stall_pct;
    int  stall_req_cnt;
    int  stall_ack_cnt;
    int  hold_left;
    int  quiet_cycles;

    reliable_rx_sequence_filter #(
        .CLIENT_SLOTS   (PEER_SLOTS),
        .FRAGMENT_LIMIT (FRAG_LIMIT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [IN_DATA_W-1:0] pack_item(input t_item it);
        return {7'd0, it.frag_total, it.frag_group, it.first_word, it.link_length,
                it.packet_type, it.checksum_ok, it.stamp_word, it.node_socket, it.network};
    endfunction

    function automatic int find_peer_slot(input logic [31:0] net, input logic [63:0] ns);
        int hit;
        hit = -1;
        for (int k = 0; k < PEER_SLOTS; k++)
            if (hit < 0 && peer_used[k] && peer_net[k] == net && peer_ns[k] == ns)
                hit = k;
        return hit;
    endfunction

    function automatic outcome_t judge_item(input t_item it);
        outcome_t    o;
        int          hit;
        int          sz;
        logic [31:0] nxt;
        o = '0;
        o.verdict = VERD_DELIVER;
        hit = find_peer_slot(it.network, it.node_socket);
        case (it.action)
            ACT_CONNECT: begin
                if (hit < 0)
                    for (int k = 0; k < PEER_SLOTS; k++)
                        if (hit < 0 && !peer_used[k]) begin
                            hit = k;
                            peer_used[k] = 1'b1;
                            peer_net[k] = it.network;
                            peer_ns[k] = it.node_socket;
                        end
                if (hit < 0) begin
                    o.verdict = VERD_TABLE_FULL;
                end else begin
                    rx_last[hit] = '0;
                    tx_last[hit] = '0;
                    grp_last[hit] = '0;
                    o.verdict = VERD_CONNECTED;
                end
            end
            ACT_DISCONNECT: begin
                if (hit < 0) begin
                    o.verdict = VERD_UNKNOWN_PEER;
                end else begin
                    peer_used[hit] = 1'b0;
                    o.verdict = VERD_DISCONNECTED;
                end
            end
            ACT_NEXT_SEND, ACT_ROLLBACK_SEND, ACT_NEXT_GROUP: begin
                if (hit < 0) begin
                    o.verdict = VERD_UNKNOWN_PEER;
                end else if (it.action == ACT_NEXT_SEND) begin
                    tx_last[hit] = tx_last[hit] + 32'd1;
                    o.id_out = tx_last[hit];
                end else if (it.action == ACT_ROLLBACK_SEND) begin
                    tx_last[hit] = tx_last[hit] - 32'd1;
                    o.id_out = tx_last[hit];
                end else begin
                    grp_last[hit] = grp_last[hit] + 32'd1;
                    o.id_out = grp_last[hit];
                end
            end
            ACT_RECEIVE: begin
                sz = int'(it.link_length) - int'(cfg_hdr);
                if (sz < 0) begin
                    o.verdict = VERD_BAD_SIZE;
                end else if (it.stamp_word != cfg_stamp) begin
                    o.verdict = VERD_BAD_STAMP;
                end else if (!it.checksum_ok) begin
                    o.verdict = VERD_BAD_CHECKSUM;
                end else if (it.packet_type == TYPE_SIMPLE) begin
                    o.size = 16'(sz);
                end else if (it.packet_type == TYPE_ACK || it.packet_type == TYPE_CANCEL) begin
                    if (sz != int'(CTRL_SIZE)) begin
                        o.verdict = VERD_MALFORMED;
                    end else begin
                        o.id_out = it.first_word;
                        if (it.packet_type == TYPE_ACK)
                            o.verdict = VERD_ACK_IN;
                        else
                            o.verdict = VERD_CANCEL_IN;
                    end
                end else if (it.packet_type != TYPE_IMPORTANT
                             && it.packet_type != TYPE_PARTIAL) begin
                    o.verdict = VERD_BAD_TYPE;
                end else if (sz < ((it.packet_type == TYPE_PARTIAL) ? int'(PARTIAL_MIN)
                                                                   : int'(IMPORTANT_MIN))) begin
                    o.verdict = VERD_MALFORMED;
                end else if (hit < 0) begin
                    o.verdict = VERD_NOT_CONNECTED;
                end else begin
                    nxt = rx_last[hit] + 32'd1;
                    if (it.first_word > nxt) begin
                        o.verdict = VERD_OUT_OF_ORDER;
                    end else if (it.first_word != nxt) begin
                        o.send_ack = 1'b1;
                        o.ack_id = it.first_word;
                        o.verdict = VERD_DUPLICATE;
                    end else if (it.packet_type == TYPE_PARTIAL) begin
                        // a fragment needs at least one payload byte
                        if (sz < int'(PARTIAL_MIN) + 1) begin
                            o.verdict = VERD_MALFORMED;
                        end else if (it.frag_total > FRAG_LIMIT) begin
                            o.verdict = VERD_TOO_MANY_FRAG;
                        end else begin
                            rx_last[hit] = nxt;
                            o.send_ack = 1'b1;
                            o.ack_id = it.first_word;
                            o.offset = PARTIAL_OFS;
                            o.size = 16'(sz - int'(PARTIAL_OFS));
                            o.group = it.frag_group;
                            o.verdict = VERD_FRAGMENT_IN;
                        end
                    end else begin
                        rx_last[hit] = nxt;
                        o.send_ack = 1'b1;
                        o.ack_id = it.first_word;
                        o.offset = IMPORTANT_OFS;
                        o.size = 16'(sz - int'(IMPORTANT_OFS));
                    end
                end
            end
            default: o.verdict = VERD_BAD_TYPE;
        endcase
        o.slot = (hit < 0) ? 3'd0 : 3'(hit);
        return o;
    endfunction

    function automatic t_item peer_item(input logic [2:0] act, input int p);
        t_item it;
        it.action = act;
        it.network = pool_net[p];
        it.node_socket = pool_ns[p];
        it.stamp_word = $urandom;
        it.checksum_ok = 1'($urandom);
        it.packet_type = 8'($urandom);
        it.link_length = 16'($urandom);
        it.first_word = $urandom;
        it.frag_group = $urandom;
        it.frag_total = 8'($urandom);
        return it;
    endfunction

    function automatic t_item hdr_item(input int p, input logic [7:0] ptype, input int sz,
                                       input logic [31:0] word);
        t_item it;
        int    ln;
        it = peer_item(ACT_RECEIVE, p);
        ln = int'(cfg_hdr) + sz;
        it.stamp_word = cfg_stamp;
        it.checksum_ok = 1'b1;
        it.packet_type = ptype;
        it.link_length = (ln > 65535) ? 16'hFFFF : 16'(ln);
        it.first_word = word;
        it.frag_total = 8'($urandom_range(FRAG_LIMIT));
        return it;
    endfunction

    function automatic t_item make_random_item();
        t_item it;
        int    pick;
        int    p;
        int    k;
        int    sz;
        int    hit;
        pick = $urandom_range(99);
        p = $urandom_range(POOL_SIZE - 1);
        it = peer_item(ACT_RECEIVE, p);
        if (pick < 8) begin
            it.action = ACT_CONNECT;
        end else if (pick < 12) begin
            it.action = ACT_DISCONNECT;
        end else if (pick < 22) begin
            k = $urandom_range(2);
            it.action = (k == 0) ? ACT_NEXT_SEND : (k == 1) ? ACT_ROLLBACK_SEND : ACT_NEXT_GROUP;
        end else if (pick < 30) begin
            // noise; junk connects would clog the table, so those keep a pool address
            it.action = 3'($urandom);
            if (it.action != ACT_CONNECT && $urandom_range(1) == 1) begin
                it.network = $urandom;
                it.node_socket = {$urandom, $urandom};
            end
        end else begin
            k = $urandom_range(99);
            if (k < 45) begin
                it.packet_type = TYPE_IMPORTANT;
                sz = ($urandom_range(99) < 90) ? $urandom_range(4, 64) : $urandom_range(0, 4);
            end else if (k < 70) begin
                it.packet_type = TYPE_PARTIAL;
                sz = ($urandom_range(99) < 85) ? $urandom_range(10, 64) : $urandom_range(7, 10);
            end else if (k < 80) begin
                it.packet_type = TYPE_SIMPLE;
                sz = $urandom_range(0, 64);
            end else if (k < 95) begin
                it.packet_type = (k < 90) ? TYPE_ACK : TYPE_CANCEL;
                sz = ($urandom_range(99) < 85) ? int'(CTRL_SIZE) : $urandom_range(0, 8);
            end else begin
                sz = $urandom_range(0, 64);
            end
            it = hdr_item(p, it.packet_type, sz, $urandom);
            if ($urandom_range(99) < 5)
                it.stamp_word = $urandom;
            if ($urandom_range(99) < 5)
                it.checksum_ok = 1'b0;
            if ($urandom_range(99) < 3 && cfg_hdr != 0)
                it.link_length = 16'($urandom_range(0, int'(cfg_hdr) - 1));
            if ($urandom_range(99) < 10)
                it.frag_total = 8'($urandom_range(FRAG_LIMIT + 1, 255));
            hit = find_peer_slot(it.network, it.node_socket);
            if (hit >= 0) begin
                k = $urandom_range(99);
                if (k < 75)
                    it.first_word = rx_last[hit] + 32'd1;
                else if (k < 87)
                    it.first_word = rx_last[hit] - 32'($urandom_range(0, 3));
                else if (k < 95)
                    it.first_word = rx_last[hit] + 32'($urandom_range(2, 4));
            end
        end
        return it;
    endfunction

    task automatic push_item(input t_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_item(it);
        s_axis_tuser <= it.action;
        do @(posedge i_clk); while (!s_axis_tready);
        awaited_outcomes.push_back(judge_item(it));
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] hdr, input logic [31:0] stamp);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_HEADER_BYTES;
        i_cfg_data <= {24'd0, hdr};
        @(posedge i_clk);
        i_cfg_idx <= CFG_STAMP_VALUE;
        i_cfg_data <= stamp;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_hdr = hdr;
        cfg_stamp = stamp;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // table fill, full table, lowest free slot, counter wrap and reconnect
    task automatic test_peer_table();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        push_item(peer_item(ACT_DISCONNECT, 0));
        push_item(peer_item(ACT_ROLLBACK_SEND, 0));
        for (int k = 0; k < PEER_SLOTS; k++)
            push_item(peer_item(ACT_CONNECT, k));
        push_item(peer_item(ACT_CONNECT, 8));
        push_item(peer_item(ACT_DISCONNECT, 3));
        push_item(peer_item(ACT_CONNECT, 8));
        push_item(peer_item(ACT_ROLLBACK_SEND, 0));
        push_item(peer_item(ACT_NEXT_GROUP, 2));
        push_item(peer_item(ACT_CONNECT, 0));
        push_item(peer_item(ACT_NEXT_SEND, 0));
    endtask

    // header checks in order, then sequencing of important and partial packets
    task automatic test_header_checks();
        t_item it;
        it = hdr_item(1, TYPE_SIMPLE, 0, 0);
        it.link_length = '0;
        push_item(it);
        it = hdr_item(1, TYPE_SIMPLE, 0, 0);
        it.stamp_word = ~cfg_stamp;
        push_item(it);
        it = hdr_item(1, TYPE_SIMPLE, 0, 0);
        it.checksum_ok = 1'b0;
        push_item(it);
        it = hdr_item(1, TYPE_SIMPLE, 0, 0);
        it.link_length = '1;
        push_item(it);
        push_item(hdr_item(1, TYPE_ACK, int'(CTRL_SIZE), $urandom));
        push_item(hdr_item(1, TYPE_CANCEL, int'(CTRL_SIZE) + 1, $urandom));
        push_item(hdr_item(1, TYPE_UNKNOWN, 4, 32'd1));
        push_item(hdr_item(1, TYPE_IMPORTANT, 3, 32'd1));
        push_item(hdr_item(9, TYPE_IMPORTANT, 8, 32'd1));
        push_item(hdr_item(1, TYPE_IMPORTANT, 8, 32'd1));
        push_item(hdr_item(1, TYPE_IMPORTANT, 8, 32'd1));
        push_item(hdr_item(1, TYPE_IMPORTANT, 8, 32'hFFFF_FFFF));
        push_item(hdr_item(1, TYPE_PARTIAL, 8, 32'd2));
        push_item(hdr_item(1, TYPE_PARTIAL, 9, 32'd2));
        it = hdr_item(1, TYPE_PARTIAL, 20, 32'd2);
        it.frag_total = 8'(FRAG_LIMIT + 1);
        push_item(it);
        it.frag_total = 8'(FRAG_LIMIT);
        push_item(it);
        push_item(peer_item(ACT_RESERVED_A, 1));
        push_item(peer_item(ACT_RESERVED_B, 1));
    endtask

    task automatic test_random_traffic(input int count, input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        repeat (count) push_item(make_random_item());
    endtask

    // output held off for a long stretch while items keep coming
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        stall_req_cnt++;
        repeat (40) push_item(make_random_item());
    endtask

    always @(posedge i_clk) begin
        if (stall_req_cnt != stall_ack_cnt) begin
            stall_ack_cnt = stall_req_cnt;
            hold_left = STALL_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        outcome_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (awaited_outcomes.size() == 0) begin
                err_count++;
                $display("%0t: result with none expected: expected nothing, actual verdict %0d",
                         $time, m_axis_tuser);
            end else begin
                want = awaited_outcomes.pop_front();
                verdict_seen[want.verdict] = 1'b1;
                check_field("verdict", 32'(m_axis_tuser), 32'(want.verdict));
                check_field("send_ack", 32'(m_axis_tdata[0]), 32'(want.send_ack));
                check_field("ack_id", m_axis_tdata[32:1], want.ack_id);
                check_field("id_out", m_axis_tdata[64:33], want.id_out);
                check_field("client_slot", 32'(m_axis_tdata[67:65]), 32'(want.slot));
                check_field("data_offset", 32'(m_axis_tdata[71:68]), 32'(want.offset));
                check_field("data_size", 32'(m_axis_tdata[87:72]), 32'(want.size));
                check_field("group_out", m_axis_tdata[119:88], want.group);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("[reliable_rx_sequence_filter] ERROR");
            $finish;
        end
    end

    initial begin
        int kinds;
        pool_net[0] = '0;
        pool_ns[0] = '0;
        pool_net[1] = '1;
        pool_ns[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++) begin
            pool_net[k] = $urandom;
            pool_ns[k] = {$urandom, $urandom};
        end
        // near misses: same network, or same node and socket
        pool_net[3] = pool_net[2];
        pool_ns[4] = pool_ns[2];
        cfg_hdr = HEADER_RESET;
        cfg_stamp = STAMP_RESET;
        for (int k = 0; k < PEER_SLOTS; k++)
            peer_used[k] = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_peer_table();
        test_header_checks();
        test_random_traffic(RANDOM_ITEMS, 0, 0);
        set_config(8'd0, 32'd0);
        test_random_traffic(RANDOM_ITEMS, 50, 0);
        set_config(8'hFF, 32'hFFFF_FFFF);
        test_random_traffic(RANDOM_ITEMS, 0, 50);
        set_config(8'($urandom_range(1, 60)), $urandom);
        test_random_traffic(RANDOM_ITEMS, 36, 36);
        test_backpressure();
        wait_drained();

        kinds = 0;
        foreach (verdict_seen[k])
            kinds += verdict_seen[k];
        $display("covered %0d items and %0d results over four handshake mixes, four",
                 items_sent, results_seen);
        $display("register settings and one long output stall; %0d distinct verdicts", kinds);
        if (err_count == 0)
            $display("[reliable_rx_sequence_filter] OK");
        else
            $display("[reliable_rx_sequence_filter] ERROR");
        $finish;
    end
endmodule

### sim.f
+incdir+sv
sv/rrsf_pkg.sv
sv/rrsf_peer_table.sv
sv/rrsf_decide.sv
sv/reliable_rx_sequence_filter.sv
sv/rrsf_checker.sv
verif/tb.sv
